>>> hdl/psab_pkg.sv
// ---------------------------------------------------------------------------
// psab_pkg
// Shared types, codes and helpers for the per-channel smoothed alpha blend.
// ---------------------------------------------------------------------------
package psab_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int ENV_INT_BITS      = 10;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 10;

    // floor(x / 1000) as (x * DIV1000_MUL) >> DIV1000_SHIFT, exact for x < 493447
    localparam logic [18:0] DIV1000_MUL   = 19'd268436;
    localparam int          DIV1000_SHIFT = 28;

    localparam logic [7:0] OPACITY_MAX = 8'd255;
    localparam logic [9:0] DRIVE_MAX   = 10'd1000;
    localparam logic [8:0] WEIGHT_FULL = 9'd256;
    localparam logic [9:0] DIV_ROUND   = 10'd500;

    localparam logic [7:0] OPACITY_LUMA_RST = 8'd150;
    localparam logic [7:0] OPACITY_CB_RST   = 8'd150;
    localparam logic [7:0] OPACITY_CR_RST   = 8'd150;
    localparam logic [9:0] LUMA_DRIVE_RST   = 10'd260;
    localparam logic [9:0] CHROMA_PUSH_RST  = 10'd180;

    typedef enum logic [1:0] {
        KIND_FRAME  = 2'd0,
        KIND_LUMA   = 2'd1,
        KIND_CHROMA = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CFG_OPACITY_LUMA = 3'd0,
        CFG_OPACITY_CB   = 3'd1,
        CFG_OPACITY_CR   = 3'd2,
        CFG_LUMA_DRIVE   = 3'd3,
        CFG_CHROMA_PUSH  = 3'd4
    } cfg_index_t;

    // envelope order during the slew sweep
    typedef enum logic [2:0] {
        ENV_LUMA_OP    = 3'd0,
        ENV_CB_OP      = 3'd1,
        ENV_CR_OP      = 3'd2,
        ENV_LUMA_DRV   = 3'd3,
        ENV_CHROMA_DRV = 3'd4
    } env_sel_t;

    // weight order during the weight sweep
    localparam logic [2:0] WGT_Y  = 3'd0;
    localparam logic [2:0] WGT_CB = 3'd1;
    localparam logic [2:0] WGT_CR = 3'd2;

    localparam logic [2:0] ENV_LAST = 3'd4;
    localparam logic [2:0] WGT_LAST = 3'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SLEW_DIFF,
        ST_SLEW_MUL,
        ST_SLEW_UPD,
        ST_WGT_RND,
        ST_WGT_MUL,
        ST_WGT_DIV,
        ST_WGT_UPD
    } psab_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_SLEW_DIFF,
        DP_SLEW_MUL,
        DP_SLEW_UPD,
        DP_WGT_RND,
        DP_WGT_MUL,
        DP_WGT_DIV,
        DP_WGT_UPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] idx;
        logic       pix_load;
    } dp_cmd_t;

    typedef struct packed {
        logic started;
        logic out_free;
    } dp_status_t;

    // rounded lerp of two samples with a 0..256 weight on the second
    function automatic logic [7:0] psab_mix(input logic [7:0] a, input logic [7:0] b,
                                            input logic [8:0] q);
        logic [16:0] acc;
        acc = 17'(a) * 17'(WEIGHT_FULL - q) + 17'(b) * 17'(q) + 17'd128;
        return acc[15:8];
    endfunction

endpackage

>>> hdl/psab_ctrl.sv
// ---------------------------------------------------------------------------
// psab_ctrl
// Sequencer: input handshake and the frame-start slew / weight sweeps.
// ---------------------------------------------------------------------------
module psab_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_kind,
    output logic                 s_ready,
    input  psab_pkg::dp_status_t status,
    output psab_pkg::dp_cmd_t    cmd
);
    import psab_pkg::*;

    psab_state_t state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic        is_pixel;
    logic        frame_acc;

    assign is_pixel  = (s_kind == KIND_LUMA) || (s_kind == KIND_CHROMA);
    assign frame_acc = s_valid && s_ready && (s_kind == KIND_FRAME);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (frame_acc) begin
                    state_next = status.started ? ST_SLEW_DIFF : ST_INIT;
                    idx_next   = 3'd0;
                end
            end
            ST_INIT:      state_next = ST_SLEW_DIFF;
            ST_SLEW_DIFF: state_next = ST_SLEW_MUL;
            ST_SLEW_MUL:  state_next = ST_SLEW_UPD;
            ST_SLEW_UPD: begin
                if (idx_reg == ENV_LAST) begin
                    state_next = ST_WGT_RND;
                    idx_next   = 3'd0;
                end else begin
                    state_next = ST_SLEW_DIFF;
                    idx_next   = idx_reg + 3'd1;
                end
            end
            ST_WGT_RND: state_next = ST_WGT_MUL;
            ST_WGT_MUL: state_next = ST_WGT_DIV;
            ST_WGT_DIV: state_next = ST_WGT_UPD;
            ST_WGT_UPD: begin
                if (idx_reg == WGT_LAST) begin
                    state_next = ST_IDLE;
                    idx_next   = 3'd0;
                end else begin
                    state_next = ST_WGT_RND;
                    idx_next   = idx_reg + 3'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd.op       = DP_NOP;
        cmd.idx      = idx_reg;
        cmd.pix_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // frame starts and spare codes need no output slot
                s_ready      = status.out_free || !is_pixel;
                cmd.pix_load = s_valid && s_ready && is_pixel;
            end
            ST_INIT:      cmd.op = DP_INIT;
            ST_SLEW_DIFF: cmd.op = DP_SLEW_DIFF;
            ST_SLEW_MUL:  cmd.op = DP_SLEW_MUL;
            ST_SLEW_UPD:  cmd.op = DP_SLEW_UPD;
            ST_WGT_RND:   cmd.op = DP_WGT_RND;
            ST_WGT_MUL:   cmd.op = DP_WGT_MUL;
            ST_WGT_DIV:   cmd.op = DP_WGT_DIV;
            ST_WGT_UPD:   cmd.op = DP_WGT_UPD;
            default:      cmd.op = DP_NOP;
        endcase
    end

    a_frame_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_acc |=> state_reg != ST_IDLE)
        else $error("frame start accepted but sequencer stayed idle");

    a_slew_to_weights: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLEW_UPD && idx_reg == ENV_LAST)
            |=> (state_reg == ST_WGT_RND && idx_reg == 3'd0))
        else $error("weight sweep did not follow the last envelope");

    a_init_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INIT |-> ($past(state_reg) == ST_IDLE && !status.started))
        else $error("envelope load outside the first frame start");

endmodule

>>> hdl/psab_dp.sv
// ---------------------------------------------------------------------------
// psab_dp
// Datapath: config registers, envelopes, weight derivation, pixel blend.
// ---------------------------------------------------------------------------
module psab_dp #(
    parameter int FRACTION_BITS = psab_pkg::FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  psab_pkg::dp_cmd_t                cmd,
    output psab_pkg::dp_status_t             status,
    input  logic                             cfg_wr_en,
    input  logic [psab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psab_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [1:0]                       s_kind,
    input  logic [7:0]                       s_first_luma,
    input  logic [7:0]                       s_second_luma,
    input  logic [7:0]                       s_first_cb,
    input  logic [7:0]                       s_second_cb,
    input  logic [7:0]                       s_first_cr,
    input  logic [7:0]                       s_second_cr,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_result_kind,
    output logic [7:0]                       m_blended_luma,
    output logic [7:0]                       m_blended_cb,
    output logic [7:0]                       m_blended_cr
);
    import psab_pkg::*;

    localparam int ENV_W  = ENV_INT_BITS + FRACTION_BITS;
    localparam int COEF_W = FRACTION_BITS;
    localparam int PROD_W = ENV_W + COEF_W;
    localparam int RND_W  = ENV_INT_BITS + 1;

    localparam longint unsigned COEF_OP_LUMA_L   = ((64'd30 << FRACTION_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned COEF_OP_CHROMA_L = ((64'd27 << FRACTION_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned COEF_DRIVE_L     = ((64'd24 << FRACTION_BITS) + 64'd50) / 64'd100;

    localparam logic [COEF_W-1:0] COEF_OP_LUMA   = COEF_W'(COEF_OP_LUMA_L);
    localparam logic [COEF_W-1:0] COEF_OP_CHROMA = COEF_W'(COEF_OP_CHROMA_L);
    localparam logic [COEF_W-1:0] COEF_DRIVE     = COEF_W'(COEF_DRIVE_L);

    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(64'd1 << (FRACTION_BITS - 1));
    localparam logic [ENV_W:0]    ENV_HALF  = (ENV_W + 1)'(64'd1 << (FRACTION_BITS - 1));

    // configuration
    logic [7:0] op_luma_reg, op_cb_reg, op_cr_reg;
    logic [9:0] luma_drive_reg, chroma_push_reg;

    // envelopes and weights
    logic [ENV_W-1:0] luma_op_env_reg, cb_op_env_reg, cr_op_env_reg;
    logic [ENV_W-1:0] luma_drv_env_reg, chroma_drv_env_reg;
    logic             started_reg;
    logic [8:0]       y_wgt_reg, cb_wgt_reg, cr_wgt_reg;

    // sweep pipeline
    logic [ENV_W-1:0]  diff_reg;
    logic              up_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [8:0]        q0_reg;
    logic [9:0]        d_reg;
    logic [17:0]       num_reg;
    logic [8:0]        quo_reg;

    // result register
    logic       m_valid_reg;
    logic [1:0] kind_out_reg;
    logic [7:0] luma_out_reg, cb_out_reg, cr_out_reg;

    // selected envelope for the slew sweep
    logic [ENV_W-1:0]  slew_env;
    logic [9:0]        slew_target;
    logic [COEF_W-1:0] slew_coef;
    logic [ENV_W-1:0]  target_full;
    logic [ENV_W-1:0]  slew_step;
    logic [ENV_W-1:0]  slew_new;

    // weight derivation
    logic [ENV_W-1:0] w_op_env, w_drv_env;
    logic [RND_W-1:0] op_int, drv_int;
    logic [7:0]       v_clamped;
    logic [9:0]       d_clamped;
    logic [36:0]      recip_prod;
    logic [9:0]       q_sum;
    logic [8:0]       q_final;

    always_comb begin
        slew_env    = luma_op_env_reg;
        slew_target = 10'(op_luma_reg);
        slew_coef   = COEF_OP_LUMA;
        unique case (cmd.idx)
            ENV_LUMA_OP: begin
                slew_env    = luma_op_env_reg;
                slew_target = 10'(op_luma_reg);
                slew_coef   = COEF_OP_LUMA;
            end
            ENV_CB_OP: begin
                slew_env    = cb_op_env_reg;
                slew_target = 10'(op_cb_reg);
                slew_coef   = COEF_OP_CHROMA;
            end
            ENV_CR_OP: begin
                slew_env    = cr_op_env_reg;
                slew_target = 10'(op_cr_reg);
                slew_coef   = COEF_OP_CHROMA;
            end
            ENV_LUMA_DRV: begin
                slew_env    = luma_drv_env_reg;
                slew_target = luma_drive_reg;
                slew_coef   = COEF_DRIVE;
            end
            ENV_CHROMA_DRV: begin
                slew_env    = chroma_drv_env_reg;
                slew_target = chroma_push_reg;
                slew_coef   = COEF_DRIVE;
            end
            default: ;
        endcase
    end

    assign target_full = ENV_W'(slew_target) << FRACTION_BITS;
    assign slew_step   = ENV_W'((prod_reg + PROD_HALF) >> FRACTION_BITS);
    // step never overshoots, so the result stays between old value and target
    assign slew_new    = up_reg ? slew_env + slew_step : slew_env - slew_step;

    always_comb begin
        w_op_env  = luma_op_env_reg;
        w_drv_env = luma_drv_env_reg;
        unique case (cmd.idx)
            WGT_Y: begin
                w_op_env  = luma_op_env_reg;
                w_drv_env = luma_drv_env_reg;
            end
            WGT_CB: begin
                w_op_env  = cb_op_env_reg;
                w_drv_env = chroma_drv_env_reg;
            end
            WGT_CR: begin
                w_op_env  = cr_op_env_reg;
                w_drv_env = chroma_drv_env_reg;
            end
            default: ;
        endcase
    end

    assign op_int     = RND_W'(((ENV_W + 1)'(w_op_env) + ENV_HALF) >> FRACTION_BITS);
    assign drv_int    = RND_W'(((ENV_W + 1)'(w_drv_env) + ENV_HALF) >> FRACTION_BITS);
    assign v_clamped  = (op_int > RND_W'(OPACITY_MAX)) ? OPACITY_MAX : op_int[7:0];
    assign d_clamped  = (drv_int > RND_W'(DRIVE_MAX)) ? DRIVE_MAX : drv_int[9:0];
    assign recip_prod = 37'(num_reg) * 37'(DIV1000_MUL);
    assign q_sum      = 10'(q0_reg) + 10'(quo_reg);
    assign q_final    = (q_sum > 10'(WEIGHT_FULL)) ? WEIGHT_FULL : q_sum[8:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_luma_reg     <= OPACITY_LUMA_RST;
            op_cb_reg       <= OPACITY_CB_RST;
            op_cr_reg       <= OPACITY_CR_RST;
            luma_drive_reg  <= LUMA_DRIVE_RST;
            chroma_push_reg <= CHROMA_PUSH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OPACITY_LUMA: op_luma_reg     <= cfg_wdata[7:0];
                CFG_OPACITY_CB:   op_cb_reg       <= cfg_wdata[7:0];
                CFG_OPACITY_CR:   op_cr_reg       <= cfg_wdata[7:0];
                CFG_LUMA_DRIVE:   luma_drive_reg  <= cfg_wdata;
                CFG_CHROMA_PUSH:  chroma_push_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // envelopes and weights
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_op_env_reg    <= '0;
            cb_op_env_reg      <= '0;
            cr_op_env_reg      <= '0;
            luma_drv_env_reg   <= '0;
            chroma_drv_env_reg <= '0;
            started_reg        <= 1'b0;
            y_wgt_reg          <= '0;
            cb_wgt_reg         <= '0;
            cr_wgt_reg         <= '0;
        end else begin
            case (cmd.op)
                DP_INIT: begin
                    luma_op_env_reg    <= ENV_W'(op_luma_reg) << FRACTION_BITS;
                    cb_op_env_reg      <= ENV_W'(op_cb_reg) << FRACTION_BITS;
                    cr_op_env_reg      <= ENV_W'(op_cr_reg) << FRACTION_BITS;
                    luma_drv_env_reg   <= ENV_W'(luma_drive_reg) << FRACTION_BITS;
                    chroma_drv_env_reg <= ENV_W'(chroma_push_reg) << FRACTION_BITS;
                    started_reg        <= 1'b1;
                end
                DP_SLEW_UPD: begin
                    case (cmd.idx)
                        ENV_LUMA_OP:    luma_op_env_reg    <= slew_new;
                        ENV_CB_OP:      cb_op_env_reg      <= slew_new;
                        ENV_CR_OP:      cr_op_env_reg      <= slew_new;
                        ENV_LUMA_DRV:   luma_drv_env_reg   <= slew_new;
                        ENV_CHROMA_DRV: chroma_drv_env_reg <= slew_new;
                        default: ;
                    endcase
                end
                DP_WGT_UPD: begin
                    case (cmd.idx)
                        WGT_Y:   y_wgt_reg  <= q_final;
                        WGT_CB:  cb_wgt_reg <= q_final;
                        WGT_CR:  cr_wgt_reg <= q_final;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // sweep pipeline, no reset needed
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_SLEW_DIFF: begin
                up_reg   <= target_full >= slew_env;
                diff_reg <= (target_full >= slew_env) ? target_full - slew_env
                                                      : slew_env - target_full;
            end
            DP_SLEW_MUL: prod_reg <= PROD_W'(diff_reg) * PROD_W'(slew_coef);
            DP_WGT_RND: begin
                // (v * 256 + 127) / 255 reduces to v + (v >= 128) for v <= 255
                q0_reg <= 9'(v_clamped) + 9'(v_clamped[7]);
                d_reg  <= d_clamped;
            end
            DP_WGT_MUL: num_reg <= 18'(WEIGHT_FULL - q0_reg) * 18'(d_reg) + 18'(DIV_ROUND);
            DP_WGT_DIV: quo_reg <= 9'(recip_prod >> DIV1000_SHIFT);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.pix_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            kind_out_reg <= s_kind;
            if (s_kind == KIND_LUMA) begin
                luma_out_reg <= psab_mix(s_first_luma, s_second_luma, y_wgt_reg);
                cb_out_reg   <= 8'd0;
                cr_out_reg   <= 8'd0;
            end else begin
                luma_out_reg <= 8'd0;
                cb_out_reg   <= psab_mix(s_first_cb, s_second_cb, cb_wgt_reg);
                cr_out_reg   <= psab_mix(s_first_cr, s_second_cr, cr_wgt_reg);
            end
        end
    end

    assign status.started  = started_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_out_reg;
    assign m_blended_luma = luma_out_reg;
    assign m_blended_cb   = cb_out_reg;
    assign m_blended_cr   = cr_out_reg;

    a_weights_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        y_wgt_reg <= WEIGHT_FULL && cb_wgt_reg <= WEIGHT_FULL && cr_wgt_reg <= WEIGHT_FULL)
        else $error("channel weight above full scale");

    a_luma_zero_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_out_reg == KIND_LUMA) |-> (cb_out_reg == 8'd0 && cr_out_reg == 8'd0))
        else $error("luma result carries chroma data");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pix_load |=> (m_valid_reg
                          && (kind_out_reg == KIND_LUMA || kind_out_reg == KIND_CHROMA)))
        else $error("pixel beat lost on its way to the result register");

endmodule

>>> hdl/per_channel_smoothed_alpha_blend_core.sv
// ---------------------------------------------------------------------------
// per_channel_smoothed_alpha_blend_core
// Two-stream YCbCr blend with smoothed per-channel weights.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------
//   s_      | in        | s_valid / s_ready | kind, first/second luma, cb, cr
//   m_      | out       | m_valid / m_ready | result_kind, blended luma, cb, cr
//   cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// Luma and chroma beats: one per cycle while idle and the result slot is free;
// each result is registered in the cycle after acceptance. Frame starts run a
// shared slew multiplier over five envelopes (diff, mul, upd), then the weight
// path over three channels (rnd, mul, div, upd); the first also loads envelopes.
// A stalled result only holds back pixel beats; frame starts still enter.
// Reset is synchronous; envelopes and weights clear to zero.
// ---------------------------------------------------------------------------
module per_channel_smoothed_alpha_blend_core #(
    parameter int FRACTION_BITS = psab_pkg::FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_kind,
    input  logic [7:0]                       s_first_luma,
    input  logic [7:0]                       s_second_luma,
    input  logic [7:0]                       s_first_cb,
    input  logic [7:0]                       s_second_cb,
    input  logic [7:0]                       s_first_cr,
    input  logic [7:0]                       s_second_cr,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_result_kind,
    output logic [7:0]                       m_blended_luma,
    output logic [7:0]                       m_blended_cb,
    output logic [7:0]                       m_blended_cr,
    input  logic                             cfg_wr_en,
    input  logic [psab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psab_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import psab_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    psab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    psab_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_kind         (s_kind),
        .s_first_luma   (s_first_luma),
        .s_second_luma  (s_second_luma),
        .s_first_cb     (s_first_cb),
        .s_second_cb    (s_second_cb),
        .s_first_cr     (s_first_cr),
        .s_second_cr    (s_second_cr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_blended_luma (m_blended_luma),
        .m_blended_cb   (m_blended_cb),
        .m_blended_cr   (m_blended_cr)
    );

endmodule
